>>> rtl/sgdw_pkg.sv
package sgdw_pkg;

    // Field widths of the stream payload.
    localparam int MV_W    = 15;
    localparam int POS_W   = 17;
    localparam int CODE_W  = 16;
    localparam int CMD_W   = 8;
    localparam int FRAME_W = CMD_W + CODE_W;

    // DAC conversion constants: gain in Q16 and the mid-scale code.
    localparam logic [CODE_W-1:0]      MID_CODE = 16'h8000;
    localparam logic signed [POS_W-1:0] LIMIT_MV = 17'sd10000;
    localparam logic signed [35:0]      GAIN_Q16 = 36'sd206158;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START_X = 3'd0;
    localparam logic [2:0] CFG_START_Y = 3'd1;
    localparam logic [2:0] CFG_END_X   = 3'd2;
    localparam logic [2:0] CFG_END_Y   = 3'd3;
    localparam logic [2:0] CFG_STEP_X  = 3'd4;
    localparam logic [2:0] CFG_STEP_Y  = 3'd5;
    localparam logic [2:0] CFG_CMD_A   = 3'd6;
    localparam logic [2:0] CFG_CMD_B   = 3'd7;

    // Request kinds carried in the input tuser.
    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_ADVANCE = 2'd1,
        REQ_DIRECT  = 2'd2
    } req_t;

    // Direct write targets.
    typedef enum logic [1:0] {
        CH_A    = 2'd0,
        CH_B    = 2'd1,
        CH_BOTH = 2'd2
    } dch_t;

    // Scan configuration as held in the register file.
    typedef struct packed {
        logic signed [MV_W-1:0] start_x;
        logic signed [MV_W-1:0] start_y;
        logic signed [MV_W-1:0] end_x;
        logic signed [MV_W-1:0] end_y;
        logic [MV_W-1:0]        step_x;
        logic [MV_W-1:0]        step_y;
        logic [CMD_W-1:0]       cmd_a;
        logic [CMD_W-1:0]       cmd_b;
    } cfg_t;

    // One result before conversion: target voltage and status flags.
    typedef struct packed {
        logic                    last;
        logic                    done;
        logic                    wv;
        logic                    ch;
        logic signed [POS_W-1:0] mv;
    } res_t;

endpackage

>>> rtl/sgdw_scan.sv
module sgdw_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  sgdw_pkg::cfg_t      cfg,
    input  logic                item_valid,
    input  logic [1:0]          item_req,
    input  logic [1:0]          item_dch,
    input  logic signed [15:0]  item_dmv,
    output logic                item_done,
    input  logic                res_ready,
    output logic                res_valid,
    output sgdw_pkg::res_t      res
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FWD   = 2'd1,
        PH_REV   = 2'd2,
        PH_YSTEP = 2'd3
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic signed [16:0]      pos_x_reg, pos_x_next;
    logic signed [16:0]      pos_y_reg, pos_y_next;
    logic                    sub_reg;
    logic                    res_valid_reg;
    sgdw_pkg::res_t          res_reg;

    logic                    slot_has;
    logic                    slot_final;
    sgdw_pkg::res_t          slot_res;
    logic                    free;
    logic                    emit;

    logic signed [17:0]      x_fwd, x_rev, y_up;
    logic signed [17:0]      end_x_w, end_y_w, start_x_w;
    logic signed [16:0]      dmv_w;

    // Row arithmetic at one extra bit so that no sum can wrap.
    assign end_x_w   = 18'(cfg.end_x);
    assign end_y_w   = 18'(cfg.end_y);
    assign start_x_w = 18'(cfg.start_x);
    assign x_fwd     = 18'(pos_x_reg) + $signed({3'b000, cfg.step_x});
    assign x_rev     = 18'(pos_x_reg) - $signed({3'b000, cfg.step_x});
    assign y_up      = 18'(pos_y_reg) + $signed({3'b000, cfg.step_y});
    assign dmv_w     = 17'(item_dmv);

    // Result of the current slot of the held item, and the scan update.
    always_comb begin
        slot_has   = 1'b0;
        slot_final = 1'b1;
        slot_res   = '0;
        phase_next = phase_reg;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        slot_res.last = 1'b1;
        case (sgdw_pkg::req_t'(item_req))
            sgdw_pkg::REQ_START: begin
                slot_has    = 1'b1;
                slot_res.wv = 1'b1;
                if (!sub_reg) begin
                    slot_final    = 1'b0;
                    slot_res.last = 1'b0;
                    slot_res.ch   = 1'b0;
                    slot_res.mv   = 17'(cfg.start_x);
                end else begin
                    slot_res.ch   = 1'b1;
                    slot_res.mv   = 17'(cfg.start_y);
                end
                pos_x_next = 17'(cfg.start_x);
                pos_y_next = 17'(cfg.start_y);
                phase_next = PH_FWD;
            end
            sgdw_pkg::REQ_DIRECT: begin
                slot_res.wv = 1'b1;
                slot_res.mv = dmv_w;
                case (sgdw_pkg::dch_t'(item_dch))
                    sgdw_pkg::CH_A: begin
                        slot_has    = 1'b1;
                        slot_res.ch = 1'b0;
                    end
                    sgdw_pkg::CH_B: begin
                        slot_has    = 1'b1;
                        slot_res.ch = 1'b1;
                    end
                    sgdw_pkg::CH_BOTH: begin
                        slot_has      = 1'b1;
                        slot_res.ch   = sub_reg;
                        slot_res.last = sub_reg;
                        slot_final    = sub_reg;
                    end
                    default: begin
                        slot_has = 1'b0;
                    end
                endcase
            end
            sgdw_pkg::REQ_ADVANCE: begin
                slot_has = 1'b1;
                unique case (phase_reg)
                    PH_FWD: begin
                        slot_res.wv = 1'b1;
                        if (x_fwd >= end_x_w) begin
                            pos_x_next = 17'(cfg.end_x);
                            phase_next = PH_YSTEP;
                        end else begin
                            pos_x_next = 17'(x_fwd);
                        end
                        slot_res.mv = pos_x_next;
                    end
                    PH_REV: begin
                        slot_res.wv = 1'b1;
                        if (x_rev <= start_x_w) begin
                            pos_x_next = 17'(cfg.start_x);
                            phase_next = PH_YSTEP;
                        end else begin
                            pos_x_next = 17'(x_rev);
                        end
                        slot_res.mv = pos_x_next;
                    end
                    PH_YSTEP: begin
                        if (18'(pos_y_reg) >= end_y_w) begin
                            slot_res.done = 1'b1;
                            phase_next    = PH_IDLE;
                        end else begin
                            slot_res.wv = 1'b1;
                            slot_res.ch = 1'b1;
                            if (y_up > end_y_w) begin
                                pos_y_next = 17'(cfg.end_y);
                            end else begin
                                pos_y_next = 17'(y_up);
                            end
                            slot_res.mv = pos_y_next;
                            if (18'(pos_x_reg) >= end_x_w) begin
                                phase_next = PH_REV;
                            end else begin
                                phase_next = PH_FWD;
                            end
                        end
                    end
                    PH_IDLE: begin
                        slot_res.done = 1'b1;
                    end
                endcase
            end
            default: begin
                slot_has = 1'b0;
            end
        endcase
    end

    // A slot moves on when the result register is free.
    assign free      = !res_valid_reg || res_ready;
    assign emit      = item_valid && free;
    assign item_done = emit && slot_final;

    // Scan state, slot index and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            sub_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                sub_reg <= !slot_final;
            end
            if (item_done) begin
                phase_reg <= phase_next;
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
            if (free) begin
                res_valid_reg <= emit && slot_has;
                res_reg       <= slot_res;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> rtl/sgdw_conv.sv
module sgdw_conv (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [sgdw_pkg::CMD_W-1:0]  cmd_a,
    input  logic [sgdw_pkg::CMD_W-1:0]  cmd_b,
    input  logic                        res_valid,
    input  sgdw_pkg::res_t              res,
    output logic                        res_ready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [47:0]                 m_tdata,
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast
);

    logic signed [16:0]              mv;
    logic signed [35:0]              prod;
    logic [sgdw_pkg::CODE_W-1:0]     code_raw;
    logic [sgdw_pkg::CODE_W-1:0]     code;
    logic [sgdw_pkg::CMD_W-1:0]      cmd;
    logic                            in_range;

    logic                            out_valid_reg;
    logic [sgdw_pkg::FRAME_W-1:0]    frame_reg;
    logic                            ch_reg;
    logic [sgdw_pkg::CODE_W-1:0]     code_reg;
    logic                            wv_reg;
    logic                            done_reg;
    logic                            last_reg;

    // Millivolts to offset-binary code: mid-scale plus floor(mv * gain / 2^16).
    assign mv       = res.mv;
    assign prod     = 36'(mv) * sgdw_pkg::GAIN_Q16;
    assign code_raw = sgdw_pkg::MID_CODE + prod[31:16];
    assign in_range = (mv <= sgdw_pkg::LIMIT_MV) && (mv >= -sgdw_pkg::LIMIT_MV);
    assign code     = in_range ? code_raw : sgdw_pkg::MID_CODE;
    assign cmd      = res.ch ? cmd_b : cmd_a;

    assign res_ready = !out_valid_reg || m_tready;

    // Output register; status results carry zero frame, channel and code.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
            if (res.wv) begin
                frame_reg <= {cmd, code};
                ch_reg    <= res.ch;
                code_reg  <= code;
            end else begin
                frame_reg <= '0;
                ch_reg    <= 1'b0;
                code_reg  <= '0;
            end
            wv_reg   <= res.wv;
            done_reg <= res.done;
            last_reg <= res.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0000000, code_reg, ch_reg, frame_reg};
    assign m_tuser  = {done_reg, wv_reg};
    assign m_tlast  = last_reg;

endmodule

>>> rtl/serpentine_galvo_scan_dac_writer.sv
// Path: each result passes through the input, scan result and output registers on its
// way to the m_ side. Throughput: one item per cycle for items with one or no result,
// while m_tready does not hold the output; start requests and direct writes to both
// channels give two results, set by one result transfer per cycle through the output register.
// Reset (aresetn low, synchronous): configuration registers take their default values,
// the scan goes idle at position zero and all stages are emptied.
module serpentine_galvo_scan_dac_writer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [1:0] direct_channel, [17:2] direct_mv, [23:18] zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [23:0] spi_frame, [24] dac_channel, [40:25] dac_code
    output logic [1:0]  m_tuser,   // [0] write_valid, [1] scan_done
    output logic        m_tlast,   // last_of_item
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    sgdw_pkg::cfg_t     cfg_reg;
    logic               i_valid_reg;
    logic [1:0]         i_req_reg;
    logic [1:0]         i_dch_reg;
    logic signed [15:0] i_dmv_reg;
    logic               item_done;
    logic               res_valid;
    logic               res_ready;
    sgdw_pkg::res_t     res;

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_x <= -15'sd5000;
            cfg_reg.start_y <= -15'sd5000;
            cfg_reg.end_x   <= 15'sd5000;
            cfg_reg.end_y   <= 15'sd5000;
            cfg_reg.step_x  <= 15'd100;
            cfg_reg.step_y  <= 15'd100;
            cfg_reg.cmd_a   <= 8'd24;
            cfg_reg.cmd_b   <= 8'd25;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sgdw_pkg::CFG_START_X: cfg_reg.start_x <= cfg_data;
                sgdw_pkg::CFG_START_Y: cfg_reg.start_y <= cfg_data;
                sgdw_pkg::CFG_END_X:   cfg_reg.end_x   <= cfg_data;
                sgdw_pkg::CFG_END_Y:   cfg_reg.end_y   <= cfg_data;
                sgdw_pkg::CFG_STEP_X:  cfg_reg.step_x  <= cfg_data;
                sgdw_pkg::CFG_STEP_Y:  cfg_reg.step_y  <= cfg_data;
                sgdw_pkg::CFG_CMD_A:   cfg_reg.cmd_a   <= cfg_data[7:0];
                sgdw_pkg::CFG_CMD_B:   cfg_reg.cmd_b   <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Input register; refills in the same cycle its item finishes.
    assign s_tready = !i_valid_reg || item_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            i_valid_reg <= 1'b1;
            i_req_reg   <= s_tuser;
            i_dch_reg   <= s_tdata[1:0];
            i_dmv_reg   <= s_tdata[17:2];
        end else if (item_done) begin
            i_valid_reg <= 1'b0;
        end
    end

    sgdw_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (i_valid_reg),
        .item_req   (i_req_reg),
        .item_dch   (i_dch_reg),
        .item_dmv   (i_dmv_reg),
        .item_done  (item_done),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    sgdw_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_a     (cfg_reg.cmd_a),
        .cmd_b     (cfg_reg.cmd_b),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
